// ===== design/sqp_pkg.sv =====
// shared types, constants and helpers of the shadow quad projection block
// no dependencies; used by shadow_quad_projection_top

package sqp_pkg;

  // input transfer payload
  typedef struct packed {
    logic signed [15:0] sun_x;
    logic signed [15:0] sun_y;
    logic signed [15:0] sun_z;
    logic signed [31:0] object_height;
    logic [30:0]        object_radius;
  } sqp_in_t;

  // output transfer payload
  typedef struct packed {
    logic [19:0]        shadow_scale;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_z;
  } sqp_out_t;

  // fixed-point constants
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] FADE_START   = 17'd1311;
  // ceil(2^47 / 31457): (x * FADE_RECIP) >> 31 is exactly (x << 16) / 31457
  localparam logic [32:0] FADE_RECIP   = 33'd4473964090;
  localparam logic [30:0] NEAR_MIN     = 31'd327680;
  localparam logic [35:0] FAR_MIN      = 36'd3276800;
  localparam logic [30:0] RADIUS_MIN   = 31'd66;
  localparam logic [19:0] SCALE_ONE    = 20'd65536;
  localparam logic [19:0] SCALE_HI     = 20'd655360;
  localparam logic [19:0] SCALE_QMAX   = 20'd589824;
  localparam logic [30:0] DIR_ONE      = 31'h4000_0000;
  localparam logic [15:0] PIVOT_RESET  = 16'h8000;

  // absolute components and flags after the input stage
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic        sx_neg;
    logic        sz_neg;
    logic [31:0] ah;
    logic [30:0] r;
    logic        unit;
  } sqp_geo_t;

  // operands after both square roots
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic        sx_neg;
    logic        sz_neg;
    logic        unit;
    logic        hzero;
    logic [29:0] hnorm;
    logic [61:0] prod;
    logic [30:0] near_l;
    logic [35:0] far_l;
    logic [33:0] base5;
  } sqp_mid_t;

  // operands carried through the ray length divide
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] az;
    logic        sx_neg;
    logic        sz_neg;
    logic        unit;
    logic        hzero;
    logic [29:0] hnorm;
    logic [33:0] base5;
    logic [35:0] lim;
  } sqp_rs_t;

  // operands carried through the scale divide
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] az;
    logic        sx_neg;
    logic        sz_neg;
    logic        unit;
    logic        hzero;
    logic [29:0] hnorm;
    logic [35:0] mlen;
  } sqp_sc_t;

  // operands carried through the direction divide
  typedef struct packed {
    logic [19:0] scale;
    logic [35:0] mlen;
    logic        sx_neg;
    logic        sz_neg;
    logic        unit;
    logic        hzero;
  } sqp_dr_t;

  // signed offset from a magnitude, saturated to 32 bits
  function automatic logic [31:0] sqp_sat_off(input logic [37:0] mag, input logic neg);
    logic [37:0] m;
    if (neg) begin
      m = (mag > 38'h0_8000_0000) ? 38'h0_8000_0000 : mag;
      return 32'(38'd0 - m);
    end else begin
      m = (mag > 38'h0_7FFF_FFFF) ? 38'h0_7FFF_FFFF : mag;
      return m[31:0];
    end
  endfunction

endpackage

// ===== design/sqp_isqrt.sv =====
// pipelined integer square root, one result bit per stage, several lanes
// depends on nothing; instanced by shadow_quad_projection_top

module sqp_isqrt #(
  parameter int unsigned RW = 30,
  parameter int unsigned LN = 2,
  parameter int unsigned SW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LN-1:0][2*RW-1:0]    rad_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LN-1:0][RW-1:0]      root_o,
  output logic [SW-1:0]              side_o
);

  logic [RW-1:0]               v_q;
  logic [SW-1:0]               side_q [RW];
  logic [LN-1:0][2*RW-1:0]     rad_q  [RW];
  logic [LN-1:0][RW+1:0]       rem_q  [RW];
  logic [LN-1:0][RW-1:0]       root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic                    v_in;
    logic [SW-1:0]           side_in;
    logic [LN-1:0][2*RW-1:0] rad_in, rad_d;
    logic [LN-1:0][RW+1:0]   rem_in, rem_d;
    logic [LN-1:0][RW-1:0]   root_in, root_d;

    // stage inputs
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // one root bit per lane
    for (genvar l = 0; l < LN; l++) begin : g_lane
      logic [RW+1:0] rem2, trial;
      logic          ge;
      assign rem2       = {rem_in[l][RW-1:0], rad_in[l][2*RW-1 -: 2]};
      assign trial      = {root_in[l], 2'b01};
      assign ge         = (rem2 >= trial);
      assign rad_d[l]   = {rad_in[l][2*RW-3:0], 2'b00};
      assign rem_d[l]   = ge ? (rem2 - trial) : rem2;
      assign root_d[l]  = {root_in[l][RW-2:0], ge};
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    // stage payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ===== design/sqp_udiv.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage, several lanes
// flags quotients that do not fit; depends on nothing

module sqp_udiv #(
  parameter int unsigned NW = 46,
  parameter int unsigned DW = 30,
  parameter int unsigned QW = 17,
  parameter int unsigned LN = 1,
  parameter int unsigned SW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [LN-1:0][NW-1:0] num_i,
  input  logic [LN-1:0][DW-1:0] den_i,
  input  logic [SW-1:0]         side_i,
  output logic                  valid_o,
  output logic [LN-1:0][QW-1:0] quo_o,
  output logic [LN-1:0]         ovf_o,
  output logic [SW-1:0]         side_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [QW-1:0]           v_q;
  logic [SW-1:0]           side_q [QW];
  logic [LN-1:0][DW-1:0]   rem_q  [QW];
  logic [LN-1:0][DW-1:0]   den_q  [QW];
  logic [LN-1:0][QW-1:0]   qn_q   [QW];
  logic [LN-1:0]           ovf_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                  v_in;
    logic [SW-1:0]         side_in;
    logic [LN-1:0][DW-1:0] rem_in, rem_d, den_in;
    logic [LN-1:0][QW-1:0] qn_in, qn_d;
    logic [LN-1:0]         ovf_in;

    // stage inputs; the first stage splits the numerator and checks range
    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      for (genvar l = 0; l < LN; l++) begin : g_init
        logic [CW-1:0] hi_ext, den_ext;
        assign hi_ext     = CW'(num_i[l][NW-1:QW]);
        assign den_ext    = CW'(den_i[l]);
        assign ovf_in[l]  = (hi_ext >= den_ext);
        assign rem_in[l]  = hi_ext[DW-1:0];
        assign qn_in[l]   = num_i[l][QW-1:0];
        assign den_in[l]  = den_i[l];
      end
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign qn_in   = qn_q[k-1];
      assign den_in  = den_q[k-1];
      assign ovf_in  = ovf_q[k-1];
    end

    // one quotient bit per lane
    for (genvar l = 0; l < LN; l++) begin : g_lane
      logic [DW:0] rem2, dext;
      logic        ge;
      assign rem2     = {rem_in[l], qn_in[l][QW-1]};
      assign dext     = {1'b0, den_in[l]};
      assign ge       = (rem2 >= dext);
      assign rem_d[l] = ge ? DW'(rem2 - dext) : rem2[DW-1:0];
      assign qn_d[l]  = {qn_in[l][QW-2:0], ge};
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    // stage payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        qn_q[k]   <= qn_d;
        ovf_q[k]  <= ovf_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = qn_q[QW-1];
  assign ovf_o   = ovf_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== design/shadow_quad_projection_top.sv =====
// top level of the shadow quad projection pipeline
// depends on sqp_pkg, sqp_isqrt and sqp_udiv

// Ground shadow quad of an object under a directional sun.
// Input channel in_valid_i/in_ready_o carries one sqp_in_t per transfer:
// sun direction, object height and radius. Output channel
// out_valid_o/out_ready_i carries one sqp_out_t per input: uniform scale
// and the x/z ground offset of the shadow origin.
// cfg_we_i/cfg_wdata_i write the pivot fraction (Q0.16); write it only
// while the pipeline is empty.
// The square roots have 30 stages and the four bit-per-stage divides have
// 17, 37, 20 and 31 stages. Throughput is one item per cycle unless the
// receiver stalls the output. Reset clears all stage valid bits and loads
// the pivot with 0.5. When the receiver stalls, the output register holds
// its result and the pipeline keeps moving while stage 11, in front of the
// output register, is empty; it stops, and in_ready_o drops, only once
// that stage holds an item too.

module shadow_quad_projection_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sqp_pkg::sqp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sqp_pkg::sqp_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  import sqp_pkg::*;

  logic en;
  logic out_free;

  // pivot register
  logic [15:0] pivot_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= PIVOT_RESET;
    end else if (cfg_we_i) begin
      pivot_q <= cfg_wdata_i;
    end
  end

  // stage 0: absolute values and special-case flags
  logic     p0_v_q;
  sqp_geo_t p0_q, p0_d;
  logic     zero_dir, no_hit;
  always_comb begin
    zero_dir  = (in_data_i.sun_x == 16'sd0) && (in_data_i.sun_y == 16'sd0) &&
                (in_data_i.sun_z == 16'sd0);
    no_hit    = (in_data_i.sun_y != 16'sd0) &&
                ((in_data_i.object_height == 32'sd0) ||
                 (in_data_i.object_height[31] == in_data_i.sun_y[15]));
    p0_d.ax     = in_data_i.sun_x[15] ? 16'(-in_data_i.sun_x) : 16'(in_data_i.sun_x);
    p0_d.ay     = in_data_i.sun_y[15] ? 16'(-in_data_i.sun_y) : 16'(in_data_i.sun_y);
    p0_d.az     = in_data_i.sun_z[15] ? 16'(-in_data_i.sun_z) : 16'(in_data_i.sun_z);
    p0_d.sx_neg = in_data_i.sun_x[15];
    p0_d.sz_neg = in_data_i.sun_z[15];
    p0_d.ah     = in_data_i.object_height[31] ? 32'(-in_data_i.object_height)
                                              : 32'(in_data_i.object_height);
    p0_d.r      = in_data_i.object_radius;
    p0_d.unit   = zero_dir || no_hit;
  end

  // stage 1: squares
  logic        p1_v_q;
  sqp_geo_t    p1_geo_q;
  logic [30:0] p1_sqx_q, p1_sqy_q, p1_sqz_q;

  // stage 2: sums of squares
  logic        p2_v_q;
  sqp_geo_t    p2_geo_q;
  logic [31:0] p2_sum3_q, p2_hsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q <= in_valid_i;
      p1_v_q <= p0_v_q;
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q      <= p0_d;
      p1_geo_q  <= p0_q;
      p1_sqx_q  <= 31'(32'(p0_q.ax) * 32'(p0_q.ax));
      p1_sqy_q  <= 31'(32'(p0_q.ay) * 32'(p0_q.ay));
      p1_sqz_q  <= 31'(32'(p0_q.az) * 32'(p0_q.az));
      p2_geo_q  <= p1_geo_q;
      p2_sum3_q <= 32'(p1_sqx_q) + 32'(p1_sqy_q) + 32'(p1_sqz_q);
      p2_hsum_q <= 32'(p1_sqx_q) + 32'(p1_sqz_q);
    end
  end

  // full and ground norms
  logic                s_v;
  logic [1:0][29:0]    s_root;
  sqp_geo_t            s_geo;

  sqp_isqrt #(.RW(30), .LN(2), .SW($bits(sqp_geo_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p2_v_q),
    .rad_i   ({{p2_sum3_q, 28'd0}, {p2_hsum_q, 28'd0}}),
    .side_i  (p2_geo_q),
    .valid_o (s_v),
    .root_o  (s_root),
    .side_o  (s_geo)
  );

  // stage 3: ray product, limit bounds, scale base
  logic        p3_v_q;
  logic [29:0] p3_norm_q;
  sqp_mid_t    p3_mid_q, p3_mid_d;
  logic [35:0] r20;
  logic [30:0] rbase;
  always_comb begin
    r20              = 36'(s_geo.r) * 36'd20;
    rbase            = (s_geo.r > RADIUS_MIN) ? s_geo.r : RADIUS_MIN;
    p3_mid_d.ax      = s_geo.ax;
    p3_mid_d.ay      = s_geo.ay;
    p3_mid_d.az      = s_geo.az;
    p3_mid_d.sx_neg  = s_geo.sx_neg;
    p3_mid_d.sz_neg  = s_geo.sz_neg;
    p3_mid_d.unit    = s_geo.unit;
    p3_mid_d.hzero   = (s_root[0] == 30'd0);
    p3_mid_d.hnorm   = s_root[0];
    p3_mid_d.prod    = 62'(s_geo.ah) * 62'(s_root[0]);
    p3_mid_d.near_l  = (s_geo.r > NEAR_MIN) ? s_geo.r : NEAR_MIN;
    p3_mid_d.far_l   = (r20 > FAR_MIN) ? r20 : FAR_MIN;
    p3_mid_d.base5   = 34'(rbase) * 34'd5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_norm_q <= s_root[1];
      p3_mid_q  <= p3_mid_d;
    end
  end

  // elevation divide
  logic        de_v;
  logic [16:0] de_q;
  logic        de_ovf;
  sqp_mid_t    de_mid;

  sqp_udiv #(.NW(46), .DW(30), .QW(17), .LN(1), .SW($bits(sqp_mid_t))) u_div_elev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3_v_q),
    .num_i   ({p3_mid_q.ay, 30'd0}),
    .den_i   (p3_norm_q),
    .side_i  (p3_mid_q),
    .valid_o (de_v),
    .quo_o   (de_q),
    .ovf_o   (de_ovf),
    .side_o  (de_mid)
  );

  // stage 4: clamp elevation, fade offset
  logic        p4_v_q;
  logic [15:0] p4_fx_q;
  sqp_mid_t    p4_mid_q;
  logic [16:0] elev;
  logic [16:0] elev_off;
  always_comb begin
    elev     = (de_ovf || (de_q > ONE_Q16)) ? ONE_Q16 : de_q;
    elev_off = elev - FADE_START;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (en) begin
      p4_v_q <= de_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_fx_q  <= (elev > FADE_START) ? elev_off[15:0] : 16'd0;
      p4_mid_q <= de_mid;
    end
  end

  // fade by reciprocal multiply
  logic        p4m_v_q;
  logic [48:0] p4m_prod_q;
  sqp_mid_t    p4m_mid_q;
  logic [17:0] fade_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4m_v_q <= 1'b0;
    end else if (en) begin
      p4m_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4m_prod_q <= 49'(p4_fx_q) * 49'(FADE_RECIP);
      p4m_mid_q  <= p4_mid_q;
    end
  end

  // stage 5: limit blend product; stage 6: limit sum
  logic        p5_v_q, p6_v_q;
  logic [52:0] p5_lp_q;
  sqp_mid_t    p5_mid_q, p6_mid_q;
  logic [35:0] p6_lim_q;
  logic [16:0] fade;
  always_comb begin
    fade_raw = p4m_prod_q[48:31];
    fade     = (fade_raw > 18'(ONE_Q16)) ? ONE_Q16 : fade_raw[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
    end else if (en) begin
      p5_v_q <= p4m_v_q;
      p6_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_lp_q  <= 53'(p4m_mid_q.far_l - 36'(p4m_mid_q.near_l)) * 53'(fade);
      p5_mid_q <= p4m_mid_q;
      p6_lim_q <= 36'(p5_mid_q.near_l) + 36'(p5_lp_q >> 16);
      p6_mid_q <= p5_mid_q;
    end
  end

  // ray length divide
  sqp_rs_t     rs_in, dr_rs;
  logic        dr_v;
  logic [36:0] dr_q;
  logic        dr_ovf;
  always_comb begin
    rs_in.ax     = p6_mid_q.ax;
    rs_in.az     = p6_mid_q.az;
    rs_in.sx_neg = p6_mid_q.sx_neg;
    rs_in.sz_neg = p6_mid_q.sz_neg;
    rs_in.unit   = p6_mid_q.unit;
    rs_in.hzero  = p6_mid_q.hzero;
    rs_in.hnorm  = p6_mid_q.hnorm;
    rs_in.base5  = p6_mid_q.base5;
    rs_in.lim    = p6_lim_q;
  end

  sqp_udiv #(.NW(62), .DW(30), .QW(37), .LN(1), .SW($bits(sqp_rs_t))) u_div_ray (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p6_v_q),
    .num_i   (p6_mid_q.prod),
    .den_i   ({p6_mid_q.ay, 14'd0}),
    .side_i  (rs_in),
    .valid_o (dr_v),
    .quo_o   (dr_q),
    .ovf_o   (dr_ovf),
    .side_o  (dr_rs)
  );

  // stage 7: capped length; stage 8: pivot product
  logic        p7_v_q, p8_v_q;
  logic [35:0] p7_len_q, p8_len_q;
  sqp_rs_t     p7_rs_q;
  logic [33:0] p8_base5_q;
  sqp_sc_t     p8_sc_q, p8_sc_d;
  always_comb begin
    p8_sc_d.ax     = p7_rs_q.ax;
    p8_sc_d.az     = p7_rs_q.az;
    p8_sc_d.sx_neg = p7_rs_q.sx_neg;
    p8_sc_d.sz_neg = p7_rs_q.sz_neg;
    p8_sc_d.unit   = p7_rs_q.unit;
    p8_sc_d.hzero  = p7_rs_q.hzero;
    p8_sc_d.hnorm  = p7_rs_q.hnorm;
    p8_sc_d.mlen   = 36'((52'(pivot_q) * 52'(p7_len_q)) >> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p7_v_q <= 1'b0;
      p8_v_q <= 1'b0;
    end else if (en) begin
      p7_v_q <= dr_v;
      p8_v_q <= p7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p7_len_q   <= (dr_ovf || (dr_q > 37'(dr_rs.lim))) ? dr_rs.lim : dr_q[35:0];
      p7_rs_q    <= dr_rs;
      p8_len_q   <= p7_len_q;
      p8_base5_q <= p7_rs_q.base5;
      p8_sc_q    <= p8_sc_d;
    end
  end

  // scale divide
  logic        ds_v;
  logic [19:0] ds_q;
  logic        ds_ovf;
  sqp_sc_t     ds_sc;

  sqp_udiv #(.NW(52), .DW(34), .QW(20), .LN(1), .SW($bits(sqp_sc_t))) u_div_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p8_v_q),
    .num_i   ({p8_len_q, 16'd0}),
    .den_i   (p8_base5_q),
    .side_i  (p8_sc_q),
    .valid_o (ds_v),
    .quo_o   (ds_q),
    .ovf_o   (ds_ovf),
    .side_o  (ds_sc)
  );

  // stage 9: clamped scale
  logic        p9_v_q;
  sqp_sc_t     p9_sc_q;
  sqp_dr_t     p9_dr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p9_v_q <= 1'b0;
    end else if (en) begin
      p9_v_q <= ds_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p9_sc_q        <= ds_sc;
      p9_dr_q.scale  <= (ds_ovf || (ds_q > SCALE_QMAX)) ? SCALE_HI : (SCALE_ONE + ds_q);
      p9_dr_q.mlen   <= ds_sc.mlen;
      p9_dr_q.sx_neg <= ds_sc.sx_neg;
      p9_dr_q.sz_neg <= ds_sc.sz_neg;
      p9_dr_q.unit   <= ds_sc.unit;
      p9_dr_q.hzero  <= ds_sc.hzero;
    end
  end

  // ground direction divide, x in lane 1 and z in lane 0
  logic              dd_v;
  logic [1:0][30:0]  dd_q;
  logic [1:0]        dd_ovf;
  sqp_dr_t           dd_dr;

  sqp_udiv #(.NW(60), .DW(30), .QW(31), .LN(2), .SW($bits(sqp_dr_t))) u_div_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p9_v_q),
    .num_i   ({{p9_sc_q.ax, 44'd0}, {p9_sc_q.az, 44'd0}}),
    .den_i   ({p9_sc_q.hnorm, p9_sc_q.hnorm}),
    .side_i  (p9_dr_q),
    .valid_o (dd_v),
    .quo_o   (dd_q),
    .ovf_o   (dd_ovf),
    .side_o  (dd_dr)
  );

  // stage 10: split products; stage 11: offset magnitudes
  logic             p10_v_q, p11_v_q;
  sqp_dr_t          p10_dr_q, p11_dr_q;
  logic [1:0][51:0] p10_hi_q;
  logic [1:0][50:0] p10_lo_q;
  logic [1:0][37:0] p11_mag_q;
  logic [1:0][30:0] dir;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dir[l] = (dd_ovf[l] || (dd_q[l] > DIR_ONE)) ? DIR_ONE : dd_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p10_v_q <= 1'b0;
      p11_v_q <= 1'b0;
    end else if (en) begin
      p10_v_q <= dd_v;
      p11_v_q <= p10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p10_dr_q <= dd_dr;
      p11_dr_q <= p10_dr_q;
      for (int l = 0; l < 2; l++) begin
        p10_hi_q[l]  <= 52'(dd_dr.mlen) * 52'(dir[l][30:15]);
        p10_lo_q[l]  <= 51'(dd_dr.mlen) * 51'(dir[l][14:0]);
        p11_mag_q[l] <= 38'((p10_hi_q[l] + 52'(p10_lo_q[l] >> 15)) >> 15);
      end
    end
  end

  // pipeline advances unless the output register is stuck and stage 11 is full
  assign out_free   = !out_valid_o || out_ready_i;
  assign en         = out_free || !p11_v_q;
  assign in_ready_o = en;

  // output register with special-case override and saturation
  sqp_out_t out_q, out_d;
  logic     out_v_q;
  logic     zero_off;
  always_comb begin
    zero_off           = p11_dr_q.unit || p11_dr_q.hzero;
    out_d.shadow_scale = p11_dr_q.unit ? SCALE_ONE : p11_dr_q.scale;
    out_d.offset_x     = zero_off ? 32'sd0 : sqp_sat_off(p11_mag_q[1], p11_dr_q.sx_neg);
    out_d.offset_z     = zero_off ? 32'sd0 : sqp_sat_off(p11_mag_q[0], p11_dr_q.sz_neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= p11_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
